// ===== sv/central_force_particle_step_core_macros.svh =====
// Assertion helpers for the particle step core. Clock is clk, reset is rst_n.
`ifndef CENTRAL_FORCE_PARTICLE_STEP_CORE_MACROS_SVH
`define CENTRAL_FORCE_PARTICLE_STEP_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CFPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CFPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CFPS_ASSERT_NOW(lbl, ante, cons, msg)
`define CFPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/cfps_pkg.sv =====
package cfps_pkg;

    localparam int unsigned AXES      = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned ID_W      = 16;
    localparam int unsigned Q_W       = 32;
    localparam int unsigned UQ_W      = 31;
    localparam int unsigned VMAG_W    = 33;

    // 1.0 in unsigned Q15.16
    localparam logic [UQ_W-1:0] CUTOFF_RESET = 31'd65536;
    localparam logic [UQ_W-1:0] GAIN_RESET   = 31'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_CUTOFF   = 3'd3,
        CFG_GAIN     = 3'd4
    } cfg_idx_t;

    typedef logic signed [Q_W-1:0] q16_t;
    typedef q16_t [AXES-1:0] vec_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        vec_t            pos;
        vec_t            vel;
        logic            last;
    } pay_t;

    typedef struct packed {
        pay_t                          pay;
        logic [AXES-1:0]               vneg;
        logic [AXES-1:0][VMAG_W-1:0]   vmag;
    } front_item_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        vec_t            new_pos;
        vec_t            new_vel;
        vec_t            prev;
        logic            last;
    } res_t;

endpackage

// ===== sv/cfps_fifo.sv =====
module cfps_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/cfps_front.sv =====
module cfps_front #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfps_pkg::vec_t        center,
    input  logic                  push,
    output logic                  full,
    input  logic [15:0]           particle_id,
    input  logic signed [31:0]    pos_x,
    input  logic signed [31:0]    pos_y,
    input  logic signed [31:0]    pos_z,
    input  logic signed [31:0]    vel_x,
    input  logic signed [31:0]    vel_y,
    input  logic signed [31:0]    vel_z,
    input  logic                  last_particle,
    output logic                  q_valid,
    input  logic                  q_pop,
    output cfps_pkg::front_item_t q_item
);
    import cfps_pkg::*;

    front_item_t                   item;
    logic [AXES-1:0][VMAG_W-1:0]   diff;
    logic [$bits(front_item_t)-1:0] q_bits;
    logic                          q_empty;

    // vector to center, split into sign and magnitude
    always_comb
    begin
        item.pay.id   = particle_id;
        item.pay.pos  = {pos_z, pos_y, pos_x};
        item.pay.vel  = {vel_z, vel_y, vel_x};
        item.pay.last = last_particle;
        for (int a = 0; a < AXES; a++)
        begin
            diff[a] = {center[a][Q_W-1], center[a]} - {item.pay.pos[a][Q_W-1], item.pay.pos[a]};
            item.vneg[a] = diff[a][VMAG_W-1];
            item.vmag[a] = diff[a][VMAG_W-1] ? (VMAG_W'(0) - diff[a]) : diff[a];
        end
    end

    cfps_fifo #(
        .WIDTH ($bits(front_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (item),
        .full      (full),
        .pop       (q_pop),
        .pop_data  (q_bits),
        .empty     (q_empty)
    );

    assign q_valid = !q_empty;
    assign q_item  = front_item_t'(q_bits);

endmodule

// ===== sv/cfps_back.sv =====
module cfps_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cfps_pkg::UQ_W-1:0]     cutoff,
    input  logic [cfps_pkg::UQ_W-1:0]     gain,
    input  logic                          q_valid,
    input  cfps_pkg::front_item_t         q_item,
    output logic                          q_pop,
    input  logic                          res_full,
    output logic                          res_push,
    output cfps_pkg::res_t                res
);
    import cfps_pkg::*;

    localparam int unsigned SQRT_STEPS = 33;
    localparam int unsigned DIVG_STEPS = 63;
    localparam int unsigned DIVN_STEPS = 31;
    localparam int unsigned SQ_W   = 65;
    localparam int unsigned RAD_W  = 66;
    localparam int unsigned ROOT_W = 33;
    localparam int unsigned SREM_W = 35;
    localparam int unsigned DSQ_W  = 66;
    localparam int unsigned N_W    = 31;
    localparam int unsigned G_W    = 63;
    localparam int unsigned GH_W   = G_W - 30;
    localparam int unsigned PH_W   = 64;
    localparam int unsigned PL_W   = 61;

    localparam int unsigned ST_SQ    = 0;
    localparam int unsigned ST_SUM   = ST_SQ + 1;
    localparam int unsigned ST_SQRT0 = ST_SUM + 1;
    localparam int unsigned ST_D     = ST_SQRT0 + SQRT_STEPS;
    localparam int unsigned ST_DIV0  = ST_D + 1;
    localparam int unsigned ST_MUL   = ST_DIV0 + DIVG_STEPS;
    localparam int unsigned ST_FRC   = ST_MUL + 1;
    localparam int unsigned ST_VEL   = ST_FRC + 1;
    localparam int unsigned ST_POS   = ST_VEL + 1;
    localparam int unsigned DEPTH    = ST_POS + 1;

    typedef struct packed {
        front_item_t                it;
        logic [AXES-1:0][SQ_W-1:0]  sq;
    } s1_t;

    typedef struct packed {
        front_item_t        it;
        logic [RAD_W-1:0]   rad;
    } s2_t;

    typedef struct packed {
        front_item_t        it;
        logic [RAD_W-1:0]   rad;
        logic [ROOT_W-1:0]  root;
        logic [SREM_W-1:0]  rem;
    } sqs_t;

    typedef struct packed {
        front_item_t        it;
        logic [ROOT_W-1:0]  d;
        logic [DSQ_W-1:0]   dsq;
        logic               frc;
    } dst_t;

    typedef struct packed {
        pay_t                         pay;
        logic [AXES-1:0]              vneg;
        logic [AXES-1:0]              vlsb;
        logic                         frc;
        logic [ROOT_W-1:0]            d;
        logic [DSQ_W-1:0]             dsq;
        logic [DSQ_W-1:0]             grem;
        logic [G_W-1:0]               gq;
        logic [AXES-1:0][ROOT_W-1:0]  nrem;
        logic [AXES-1:0][N_W-1:0]     nq;
    } dvs_t;

    typedef struct packed {
        pay_t                         pay;
        logic [AXES-1:0]              vneg;
        logic                         frc;
        logic [AXES-1:0][PH_W-1:0]    p_hi;
        logic [AXES-1:0][PL_W-1:0]    p_lo;
    } mul_t;

    typedef struct packed {
        pay_t                         pay;
        logic [AXES-1:0][Q_W:0]       dv;
    } frc_t;

    typedef struct packed {
        pay_t   pay;
        vec_t   nv;
    } vel_t;

    function automatic logic [Q_W-1:0] sat34(input logic [Q_W+1:0] x);
        logic [Q_W-1:0] r;
        r = x[Q_W-1:0];
        if (!x[Q_W+1] && (x[Q_W:Q_W-1] != 2'b00))
        begin
            r = {1'b0, {(Q_W-1){1'b1}}};
        end
        else if (x[Q_W+1] && (x[Q_W:Q_W-1] != 2'b11))
        begin
            r = {1'b1, {(Q_W-1){1'b0}}};
        end
        return r;
    endfunction

    // one result bit of the restoring square root
    function automatic sqs_t sqrt_step(input sqs_t p, input int unsigned i);
        sqs_t              n;
        logic [SREM_W+1:0] rw;
        logic [SREM_W+1:0] trial;
        n     = p;
        rw    = {p.rem, p.rad[2*i +: 2]};
        trial = {2'b00, p.root, 2'b01};
        if (rw >= trial)
        begin
            n.rem  = SREM_W'(rw - trial);
            n.root = {p.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            n.rem  = rw[SREM_W-1:0];
            n.root = {p.root[ROOT_W-2:0], 1'b0};
        end
        return n;
    endfunction

    // one quotient bit of gain*2^32/d^2, and of |v|*2^30/d for the first steps
    function automatic dvs_t div_step(input dvs_t p, input int j, input logic [UQ_W-1:0] gn);
        dvs_t              n;
        logic [DSQ_W:0]    gw;
        logic [ROOT_W:0]   nw;
        logic              gb;
        logic              nb;
        int                k;
        n  = p;
        k  = G_W - 1 - j;
        gb = (k >= 32) ? gn[k - 32] : 1'b0;
        gw = {p.grem, gb};
        if (gw >= {1'b0, p.dsq})
        begin
            n.grem = DSQ_W'(gw - {1'b0, p.dsq});
            n.gq   = {p.gq[G_W-2:0], 1'b1};
        end
        else
        begin
            n.grem = gw[DSQ_W-1:0];
            n.gq   = {p.gq[G_W-2:0], 1'b0};
        end
        if (j < DIVN_STEPS)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                nb = (j == 0) ? p.vlsb[a] : 1'b0;
                nw = {p.nrem[a], nb};
                if (nw >= {1'b0, p.d})
                begin
                    n.nrem[a] = ROOT_W'(nw - {1'b0, p.d});
                    n.nq[a]   = {p.nq[a][N_W-2:0], 1'b1};
                end
                else
                begin
                    n.nrem[a] = nw[ROOT_W-1:0];
                    n.nq[a]   = {p.nq[a][N_W-2:0], 1'b0};
                end
            end
        end
        return n;
    endfunction

    logic               adv;
    logic [DEPTH-1:0]   vld_reg;

    s1_t    s1_reg, s1_next;
    s2_t    s2_reg, s2_next;
    sqs_t   sqs_seed;
    sqs_t   sqs_in   [SQRT_STEPS];
    sqs_t   sqs_next [SQRT_STEPS];
    sqs_t   sqs_reg  [SQRT_STEPS];
    dst_t   dst_reg, dst_next;
    dvs_t   dvs_seed;
    dvs_t   dvs_in   [DIVG_STEPS];
    dvs_t   dvs_next [DIVG_STEPS];
    dvs_t   dvs_reg  [DIVG_STEPS];
    mul_t   mul_reg, mul_next;
    frc_t   frc_reg, frc_next;
    vel_t   vel_reg, vel_next;
    res_t   res_reg, res_next;

    logic [AXES-1:0][2*VMAG_W-1:0] sq_full;
    logic [2*ROOT_W-1:0]           d_sq_full;
    logic [GH_W-1:0]               g_hi;
    logic [29:0]                   g_lo;
    logic [AXES-1:0][PH_W-1:0]     m_sum;
    logic [AXES-1:0][Q_W-1:0]      m_mag;
    logic [AXES-1:0][Q_W+1:0]      v_sum;
    logic [AXES-1:0][Q_W+1:0]      p_sum;

    // whole pipeline holds while the result buffer is full
    assign adv      = !res_full;
    assign q_pop    = adv && q_valid;
    assign res_push = adv && vld_reg[ST_POS];
    assign res      = res_reg;

    // squares of the vector components
    always_comb
    begin
        s1_next.it = q_item;
        for (int a = 0; a < AXES; a++)
        begin
            sq_full[a]    = q_item.vmag[a] * q_item.vmag[a];
            s1_next.sq[a] = sq_full[a][SQ_W-1:0];
        end
    end

    always_comb
    begin
        s2_next.it  = s1_reg.it;
        s2_next.rad = {1'b0, s1_reg.sq[0]} + {1'b0, s1_reg.sq[1]} + {1'b0, s1_reg.sq[2]};
    end

    always_comb
    begin
        sqs_seed.it   = s2_reg.it;
        sqs_seed.rad  = s2_reg.rad;
        sqs_seed.root = '0;
        sqs_seed.rem  = '0;
    end

    for (genvar t = 0; t < SQRT_STEPS; t++)
    begin : g_sqrt
        if (t == 0)
        begin : g_first
            assign sqs_in[t] = sqs_seed;
        end
        else
        begin : g_rest
            assign sqs_in[t] = sqs_reg[t-1];
        end
        assign sqs_next[t] = sqrt_step(sqs_in[t], SQRT_STEPS - 1 - t);
    end

    // length, its square and the cutoff decision
    always_comb
    begin
        dst_next.it  = sqs_reg[SQRT_STEPS-1].it;
        dst_next.d   = sqs_reg[SQRT_STEPS-1].root;
        d_sq_full    = dst_next.d * dst_next.d;
        dst_next.dsq = d_sq_full[DSQ_W-1:0];
        dst_next.frc = (dst_next.d > {2'b00, cutoff});
    end

    always_comb
    begin
        dvs_seed.pay  = dst_reg.it.pay;
        dvs_seed.vneg = dst_reg.it.vneg;
        dvs_seed.frc  = dst_reg.frc;
        dvs_seed.d    = dst_reg.d;
        dvs_seed.dsq  = dst_reg.dsq;
        dvs_seed.grem = '0;
        dvs_seed.gq   = '0;
        for (int a = 0; a < AXES; a++)
        begin
            dvs_seed.vlsb[a] = dst_reg.it.vmag[a][0];
            dvs_seed.nrem[a] = {1'b0, dst_reg.it.vmag[a][VMAG_W-1:1]};
            dvs_seed.nq[a]   = '0;
        end
    end

    for (genvar j = 0; j < DIVG_STEPS; j++)
    begin : g_div
        if (j == 0)
        begin : g_first
            assign dvs_in[j] = dvs_seed;
        end
        else
        begin : g_rest
            assign dvs_in[j] = dvs_reg[j-1];
        end
        assign dvs_next[j] = div_step(dvs_in[j], j, gain);
    end

    // unit vector times gain/d^2, split into two partial products
    always_comb
    begin
        mul_next.pay  = dvs_reg[DIVG_STEPS-1].pay;
        mul_next.vneg = dvs_reg[DIVG_STEPS-1].vneg;
        mul_next.frc  = dvs_reg[DIVG_STEPS-1].frc;
        g_hi = dvs_reg[DIVG_STEPS-1].gq[G_W-1:30];
        g_lo = dvs_reg[DIVG_STEPS-1].gq[29:0];
        for (int a = 0; a < AXES; a++)
        begin
            mul_next.p_hi[a] = dvs_reg[DIVG_STEPS-1].nq[a] * g_hi;
            mul_next.p_lo[a] = dvs_reg[DIVG_STEPS-1].nq[a] * g_lo;
        end
    end

    // force term, saturated asymmetrically by sign
    always_comb
    begin
        frc_next.pay = mul_reg.pay;
        for (int a = 0; a < AXES; a++)
        begin
            m_sum[a] = mul_reg.p_hi[a] + PH_W'(mul_reg.p_lo[a][PL_W-1:30]);
            if (mul_reg.vneg[a])
            begin
                m_mag[a] = (m_sum[a] > PH_W'(64'h8000_0000)) ? 32'h8000_0000 : m_sum[a][Q_W-1:0];
            end
            else
            begin
                m_mag[a] = (m_sum[a] > PH_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : m_sum[a][Q_W-1:0];
            end
            if (!mul_reg.frc)
            begin
                frc_next.dv[a] = '0;
            end
            else if (mul_reg.vneg[a])
            begin
                frc_next.dv[a] = (Q_W+1)'(0) - {1'b0, m_mag[a]};
            end
            else
            begin
                frc_next.dv[a] = {1'b0, m_mag[a]};
            end
        end
    end

    always_comb
    begin
        vel_next.pay = frc_reg.pay;
        for (int a = 0; a < AXES; a++)
        begin
            v_sum[a] = {{2{frc_reg.pay.vel[a][Q_W-1]}}, frc_reg.pay.vel[a]}
                     + {frc_reg.dv[a][Q_W], frc_reg.dv[a]};
            vel_next.nv[a] = sat34(v_sum[a]);
        end
    end

    always_comb
    begin
        res_next.id      = vel_reg.pay.id;
        res_next.last    = vel_reg.pay.last;
        res_next.new_vel = vel_reg.nv;
        res_next.prev    = vel_reg.pay.pos;
        for (int a = 0; a < AXES; a++)
        begin
            p_sum[a] = {{2{vel_reg.pay.pos[a][Q_W-1]}}, vel_reg.pay.pos[a]}
                     + {{2{vel_reg.nv[a][Q_W-1]}}, vel_reg.nv[a]};
            res_next.new_pos[a] = sat34(p_sum[a]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], q_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            for (int t = 0; t < SQRT_STEPS; t++)
            begin
                sqs_reg[t] <= sqs_next[t];
            end
            dst_reg <= dst_next;
            for (int j = 0; j < DIVG_STEPS; j++)
            begin
                dvs_reg[j] <= dvs_next[j];
            end
            mul_reg <= mul_next;
            frc_reg <= frc_next;
            vel_reg <= vel_next;
            res_reg <= res_next;
        end
    end

endmodule

// ===== sv/central_force_particle_step_core.sv =====
// Central force particle step: one Euler step of an inverse-square pull toward
// a programmable center, one particle per request.
// Input side is a queue write port: a request is taken when push is high and
// full is low. Result side is a queue read port: the oldest result sits on the
// result ports while empty is low and leaves when pop is high.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// write it only while no request is in flight.
// Throughput: one request per cycle, sustained, as long as results are popped.
// The pipeline depth comes from the 33-step square root and the 63-step
// divider for gain/d^2, one step per pipeline stage; the unit-vector
// dividers run beside the latter.
// If results are not popped, the output buffer fills, the back end freezes in
// place, the input queue fills and full rises; nothing is dropped.
// Reset clears all valid state and loads center 0, cutoff 1.0, gain 1.0.
`include "central_force_particle_step_core_macros.svh"
module central_force_particle_step_core #(
    parameter int unsigned QUEUE_DEPTH = 4,
    parameter int unsigned OUT_DEPTH   = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    // request side
    input  logic                push,
    output logic                full,
    input  logic [15:0]         particle_id,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [31:0]  vel_x,
    input  logic signed [31:0]  vel_y,
    input  logic signed [31:0]  vel_z,
    input  logic                last_particle,
    // result side
    output logic                empty,
    input  logic                pop,
    output logic [15:0]         out_id,
    output logic signed [31:0]  new_pos_x,
    output logic signed [31:0]  new_pos_y,
    output logic signed [31:0]  new_pos_z,
    output logic signed [31:0]  new_vel_x,
    output logic signed [31:0]  new_vel_y,
    output logic signed [31:0]  new_vel_z,
    output logic signed [31:0]  prev_x,
    output logic signed [31:0]  prev_y,
    output logic signed [31:0]  prev_z,
    output logic                out_last,
    // config writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import cfps_pkg::*;

    vec_t                     center_reg;
    logic [UQ_W-1:0]          cutoff_reg;
    logic [UQ_W-1:0]          gain_reg;

    logic                     q_valid;
    logic                     q_pop;
    front_item_t              q_item;
    logic                     res_full;
    logic                     res_push;
    res_t                     res_in;
    logic [$bits(res_t)-1:0]  res_bits;
    res_t                     res_out;

    assign cfg_ready = 1'b1;

    // register file; fields not listed ignore the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= '0;
            cutoff_reg <= CUTOFF_RESET;
            gain_reg   <= GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CENTER_X: center_reg[0] <= cfg_data;
                CFG_CENTER_Y: center_reg[1] <= cfg_data;
                CFG_CENTER_Z: center_reg[2] <= cfg_data;
                CFG_CUTOFF:   cutoff_reg    <= cfg_data[UQ_W-1:0];
                CFG_GAIN:     gain_reg      <= cfg_data[UQ_W-1:0];
                default:      ;
            endcase
        end
    end

    // front end: vector to center, then the decoupling queue
    cfps_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .center        (center_reg),
        .push          (push),
        .full          (full),
        .particle_id   (particle_id),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .vel_x         (vel_x),
        .vel_y         (vel_y),
        .vel_z         (vel_z),
        .last_particle (last_particle),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item)
    );

    // back end: length, force, velocity and position update
    cfps_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cutoff   (cutoff_reg),
        .gain     (gain_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res_in)
    );

    // result buffer parts the pipeline from the consumer
    cfps_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_bits),
        .empty     (empty)
    );

    assign res_out   = res_t'(res_bits);
    assign out_id    = res_out.id;
    assign new_pos_x = res_out.new_pos[0];
    assign new_pos_y = res_out.new_pos[1];
    assign new_pos_z = res_out.new_pos[2];
    assign new_vel_x = res_out.new_vel[0];
    assign new_vel_y = res_out.new_vel[1];
    assign new_vel_z = res_out.new_vel[2];
    assign prev_x    = res_out.prev[0];
    assign prev_y    = res_out.prev[1];
    assign prev_z    = res_out.prev[2];
    assign out_last  = res_out.last;

    `CFPS_ASSERT_NOW(a_no_push_into_full, res_full, !res_push, "result pushed into full buffer")
    `CFPS_ASSERT_NOW(a_stall_holds_queue, res_full, !q_pop, "queue popped during back-end stall")
    `CFPS_ASSERT_NEXT(a_accept_lands, push && !full, q_valid, "accepted request not in queue")

endmodule

// ===== test/central_force_particle_step_core_tb.sv =====
`timescale 1ns / 100ps

module central_force_particle_step_core_tb;
    import cfps_pkg::*;

    // one particle request as driven onto the input ports
    typedef struct {
        logic [15:0]        id;
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        logic               last;
    } particle_t;

    // one expected step result
    typedef struct {
        logic [15:0]        id;
        logic signed [31:0] npos [3];
        logic signed [31:0] nvel [3];
        logic signed [31:0] prev [3];
        logic               last;
    } step_t;

    int unsigned mismatch_count = 0;

    function automatic void report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        mismatch_count++;
    endfunction

    // Step predictor: holds its own copy of the field registers.
    class step_scoreboard;
        longint            ctr [3];
        longint unsigned   cutoff;
        longint unsigned   gain;
        step_t             pending [$];
        int unsigned       checked;

        function new();
            ctr = '{0, 0, 0};
            cutoff = 65536;
            gain = 65536;
            checked = 0;
        endfunction

        function void write_reg(input cfg_idx_t idx, input logic [31:0] data);
            case (idx)
                CFG_CENTER_X: ctr[0] = longint'(signed'(data));
                CFG_CENTER_Y: ctr[1] = longint'(signed'(data));
                CFG_CENTER_Z: ctr[2] = longint'(signed'(data));
                CFG_CUTOFF:   cutoff = data[30:0];
                CFG_GAIN:     gain = data[30:0];
                default: ;
            endcase
        endfunction

        static function longint clamp32(input longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        // bitwise integer root of a 66-bit sum of squares
        static function longint unsigned root66(input logic [65:0] s);
            logic [67:0] rem;
            logic [67:0] trial;
            logic [33:0] r;
            rem = 0;
            r = 0;
            for (int i = 32; i >= 0; i--) begin
                rem = (rem << 2) | s[2*i +: 2];
                trial = {r, 2'b01};
                if (rem >= trial) begin
                    rem = rem - trial;
                    r = (r << 1) | 1;
                end
                else
                    r = r << 1;
            end
            return r;
        endfunction

        function void note_request(input particle_t p);
            step_t e;
            longint v [3];
            longint dv [3];
            logic [65:0] sumsq;
            logic [32:0] a;
            longint unsigned d, g, n, m;
            sumsq = 0;
            for (int i = 0; i < 3; i++) begin
                v[i] = ctr[i] - longint'(p.pos[i]);
                a = (v[i] < 0) ? 33'(-v[i]) : 33'(v[i]);
                sumsq = sumsq + 66'(a) * 66'(a);
                dv[i] = 0;
            end
            d = root66(sumsq);
            if (d > cutoff) begin
                g = ((gain << 32) / d) / d;
                for (int i = 0; i < 3; i++) begin
                    a = (v[i] < 0) ? 33'(-v[i]) : 33'(v[i]);
                    n = (64'(a) << 30) / d;
                    m = n * (g >> 30) + ((n * (g & 64'h3FFF_FFFF)) >> 30);
                    if (v[i] < 0) begin
                        if (m > 64'h8000_0000) m = 64'h8000_0000;
                        dv[i] = -longint'(m);
                    end
                    else begin
                        if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
                        dv[i] = m;
                    end
                end
            end
            e.id = p.id;
            e.last = p.last;
            for (int i = 0; i < 3; i++) begin
                longint nv;
                longint np;
                nv = clamp32(longint'(p.vel[i]) + dv[i]);
                np = clamp32(longint'(p.pos[i]) + nv);
                e.nvel[i] = nv[31:0];
                e.npos[i] = np[31:0];
                e.prev[i] = p.pos[i];
            end
            pending.push_back(e);
        endfunction

        function void check_result(input step_t r);
            step_t e;
            string ax [3];
            ax = '{"x", "y", "z"};
            if (pending.size() == 0) begin
                report("unexpected result id", r.id, 0);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (r.id !== e.id) report("out_id", r.id, e.id);
            if (r.last !== e.last) report("out_last", r.last, e.last);
            for (int i = 0; i < 3; i++) begin
                if (r.npos[i] !== e.npos[i])
                    report({"new_pos_", ax[i]}, r.npos[i], e.npos[i]);
                if (r.nvel[i] !== e.nvel[i])
                    report({"new_vel_", ax[i]}, r.nvel[i], e.nvel[i]);
                if (r.prev[i] !== e.prev[i])
                    report({"prev_", ax[i]}, r.prev[i], e.prev[i]);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [15:0]        particle_id;
    logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
    logic               last_particle;
    logic               empty;
    logic               pop;
    logic [15:0]        out_id;
    logic signed [31:0] new_pos_x, new_pos_y, new_pos_z;
    logic signed [31:0] new_vel_x, new_vel_y, new_vel_z;
    logic signed [31:0] prev_x, prev_y, prev_z;
    logic               out_last;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    central_force_particle_step_core u_top (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full),
        .particle_id(particle_id),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
        .last_particle(last_particle),
        .empty(empty), .pop(pop),
        .out_id(out_id),
        .new_pos_x(new_pos_x), .new_pos_y(new_pos_y), .new_pos_z(new_pos_z),
        .new_vel_x(new_vel_x), .new_vel_y(new_vel_y), .new_vel_z(new_vel_z),
        .prev_x(prev_x), .prev_y(prev_y), .prev_z(prev_z),
        .out_last(out_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    step_scoreboard sb;
    int unsigned    sent = 0;
    bit             sending_done = 0;
    // draining mode: receiver pops back to back, used around config phases
    bit             drain_fast = 0;
    // Settle time before config writes and at the end.
    localparam int SETTLE = 130;

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Safety net: ~1500 requests with random push gaps and pop stalls plus pipeline
    // depth fit well within this bound; allow about 4 ms.
    initial
    begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    // --- request side helpers --------------------------------------------

    // push stays high after a request is taken so that a zero gap gives
    // back-to-back requests; the gap cycles or push_idle drop it
    task automatic push_particle(input particle_t p);
        int gap;
        gap = $urandom_range(0, 15);
        // runs of back-to-back requests are common on purpose
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        particle_id <= p.id;
        pos_x <= p.pos[0]; pos_y <= p.pos[1]; pos_z <= p.pos[2];
        vel_x <= p.vel[0]; vel_y <= p.vel[1]; vel_z <= p.vel[2];
        last_particle <= p.last;
        // request is taken at the rising edge where full is low
        forever
        begin
            @(posedge clk);
            if (!full) break;
        end
        sb.note_request(p);
        sent++;
    endtask

    task automatic push_idle();
        @(negedge clk);
        push <= 1'b0;
    endtask

    // wait until every expected result has been popped, then let the pipe settle
    task automatic wait_drained();
        push_idle();
        drain_fast = 1;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        drain_fast = 0;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;  // near zero
            3: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic particle_t rand_particle();
        particle_t p;
        p.id = $urandom;
        for (int i = 0; i < 3; i++)
        begin
            p.pos[i] = rand_q();
            p.vel[i] = rand_q();
        end
        p.last = $urandom_range(0, 1);
        return p;
    endfunction

    function automatic particle_t mk(input logic [15:0] id, input logic [31:0] px,
                                     input logic [31:0] py, input logic [31:0] pz,
                                     input logic [31:0] vx, input logic [31:0] vy,
                                     input logic [31:0] vz, input logic lst);
        particle_t p;
        p.id = id; p.last = lst;
        p.pos = '{px, py, pz};
        p.vel = '{vx, vy, vz};
        return p;
    endfunction

    // random field configuration; extremes picked now and then
    task automatic random_config();
        logic [31:0] c;
        for (int i = 0; i < 3; i++)
        begin
            c = ($urandom_range(0, 2) == 0) ? rand_q()
                : ($urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
            write_reg(cfg_idx_t'(i), c);
        end
        case ($urandom_range(0, 3))
            0: c = 0;
            1: c = 32'h7FFF_FFFF;
            2: c = $urandom_range(0, 32'h0010_0000);
            default: c = $urandom;
        endcase
        write_reg(CFG_CUTOFF, c);
        case ($urandom_range(0, 3))
            0: c = 0;
            1: c = 32'h7FFF_FFFF;
            2: c = $urandom_range(0, 32'h0100_0000);
            default: c = $urandom;
        endcase
        write_reg(CFG_GAIN, c);
    endtask

    // --- result side -----------------------------------------------------

    initial
    begin
        step_t r;
        int    stall;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = drain_fast ? 0 : $urandom_range(0, 15);
            if (!drain_fast && $urandom_range(0, 3) == 0) stall = 0;
            repeat (stall)
            begin
                @(negedge clk);
                pop <= 1'b0;
            end
            @(negedge clk);
            pop <= 1'b1;
            forever
            begin
                @(posedge clk);
                if (!empty) break;
            end
            r.id = out_id;
            r.last = out_last;
            r.npos = '{new_pos_x, new_pos_y, new_pos_z};
            r.nvel = '{new_vel_x, new_vel_y, new_vel_z};
            r.prev = '{prev_x, prev_y, prev_z};
            sb.check_result(r);
        end
    end

    // --- main sequence ---------------------------------------------------

    initial
    begin
        particle_t p;
        int        timer;
        sb = new();
        rst_n = 1'b0;
        push = 1'b0;
        particle_id = '0;
        pos_x = '0; pos_y = '0; pos_z = '0;
        vel_x = '0; vel_y = '0; vel_z = '0;
        last_particle = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CENTER_X;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, reset fields: center at origin, cutoff 1.0, gain 1.0.
        // at the center itself: zero length, no pull
        push_particle(mk(16'h0000, 0, 0, 0, 0, 0, 0, 1'b0));
        // exactly on the cutoff: d == cutoff, still no pull
        push_particle(mk(16'hFFFF, 32'h0001_0000, 0, 0, 32'h0000_1234, 0, 0, 1'b1));
        // just outside the cutoff on each axis, both signs
        push_particle(mk(16'h0001, 32'h0001_0001, 0, 0, 0, 0, 0, 1'b0));
        push_particle(mk(16'h0002, 0, 32'hFFFE_FFFF, 0, 0, 0, 0, 1'b1));
        push_particle(mk(16'h0003, 0, 0, 32'h0002_0000, 0, 0, 0, 1'b0));
        // field corners: longest possible vector
        push_particle(mk(16'h8000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        push_particle(mk(16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        // velocity and position saturation
        push_particle(mk(16'h0010, 32'h7FFF_0000, 32'h8000_1000, 32'h0000_0000,
                         32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b1));
        // close but outside the cutoff
        push_particle(mk(16'h0011, 32'h0001_0002, 32'hFFFF_0000, 32'h0000_8000,
                         32'h7FFF_0000, 32'h8001_0000, 0, 1'b0));
        wait_drained();

        // Extreme fields: far center, cutoff zero, largest gain.
        write_reg(CFG_CENTER_X, 32'h7FFF_FFFF);
        write_reg(CFG_CENTER_Y, 32'h8000_0000);
        write_reg(CFG_CENTER_Z, 32'h0000_0000);
        write_reg(CFG_CUTOFF, 32'h0000_0000);
        write_reg(CFG_GAIN, 32'h7FFF_FFFF);
        push_particle(mk(16'h0020, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                         0, 0, 0, 1'b1));
        push_particle(mk(16'h0021, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h1234_5678, 32'hEDCB_A987, 0, 1'b0));
        push_particle(mk(16'h0022, 32'h7FFF_FFFF, 32'h8000_0001, 0, 0, 0, 0, 1'b1));
        push_particle(mk(16'h0023, 0, 0, 0, 32'hFFFF_FFFF, 1, 32'h8000_0000, 1'b0));
        wait_drained();

        // Other extreme: huge cutoff, no gain.
        write_reg(CFG_CENTER_X, 32'h8000_0000);
        write_reg(CFG_CENTER_Y, 32'h7FFF_FFFF);
        write_reg(CFG_CENTER_Z, 32'hFFFF_FFFF);
        write_reg(CFG_CUTOFF, 32'h7FFF_FFFF);
        write_reg(CFG_GAIN, 32'h0000_0000);
        push_particle(mk(16'h0030, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
        push_particle(mk(16'h0031, 0, 0, 0, 32'h0001_0000, 0, 0, 1'b0));
        wait_drained();
        write_reg(CFG_CUTOFF, 32'h0000_0000);
        push_particle(mk(16'h0032, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
        wait_drained();

        // Random phases: new field settings between phases, full drain before each.
        for (int phase = 0; phase < 12; phase++)
        begin
            random_config();
            for (int k = 0; k < 120; k++)
            begin
                p = rand_particle();
                push_particle(p);
            end
            wait_drained();
        end

        // one last run of random requests at reset-like fields
        write_reg(CFG_CENTER_X, 0);
        write_reg(CFG_CENTER_Y, 0);
        write_reg(CFG_CENTER_Z, 0);
        write_reg(CFG_CUTOFF, 32'h0001_0000);
        write_reg(CFG_GAIN, 32'h0001_0000);
        for (int k = 0; k < 30; k++)
            push_particle(rand_particle());
        push_idle();
        sending_done = 1;

        timer = 0;
        drain_fast = 1;
        while (sb.pending.size() != 0 && timer < 20000)
        begin
            @(posedge clk);
            timer++;
        end
        repeat (SETTLE) @(posedge clk);
        drain_fast = 0;

        $display("Run covered %0d particle requests, %0d step results checked,",
                 sent, sb.checked);
        $display("under reset fields, directed extremes and 12 random field settings.");
        if (mismatch_count == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
        begin
            if (sb.pending.size() != 0)
                $display("%0d expected results never arrived", sb.pending.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/cfps_pkg.sv
sv/cfps_fifo.sv
sv/cfps_front.sv
sv/cfps_back.sv
sv/central_force_particle_step_core.sv
test/central_force_particle_step_core_tb.sv
